[hdl/line_framed_rx_fifo_core_macros.svh]
// assertion helpers, clocked on clk and disabled in reset
`ifndef LINE_FRAMED_RX_FIFO_CORE_MACROS_SVH
`define LINE_FRAMED_RX_FIFO_CORE_MACROS_SVH

// same-cycle implication
`define LFRF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFRF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lfrf_pkg.sv]
`default_nettype none
package lfrf_pkg;

	localparam int DEPTH = 2048;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW > 6) ? AW : 6;
	localparam int LINE_MAX = 64;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_CHUNK = 2'd2;

	localparam logic [2:0] ST_STORED = 3'd0;
	localparam logic [2:0] ST_DROPPED = 3'd1;
	localparam logic [2:0] ST_LINE_BYTE = 3'd2;
	localparam logic [2:0] ST_LINE_END = 3'd3;
	localparam logic [2:0] ST_NO_LINE = 3'd4;
	localparam logic [2:0] ST_CHUNK_BYTE = 3'd5;
	localparam logic [2:0] ST_EMPTY = 3'd6;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] data_byte;
		logic [5:0] line_length;
		logic [7:0] term_first;
		logic [1:0] term_count;
		logic last;
	} res_t;

	function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage
`default_nettype wire

[hdl/lfrf_if.sv]
`default_nettype none
interface lfrf_in_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [7:0] rx_byte;
	logic [5:0] max_count;
	modport source (output valid, output kind, output rx_byte, output max_count, input ready);
	modport sink (input valid, input kind, input rx_byte, input max_count, output ready);
endinterface

interface lfrf_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [7:0] data_byte;
	logic [5:0] line_length;
	logic [7:0] term_first;
	logic [1:0] term_count;
	logic last;
	modport source (output valid, output status, output data_byte, output line_length,
		output term_first, output term_count, output last, input ready);
	modport sink (input valid, input status, input data_byte, input line_length,
		input term_first, input term_count, input last, output ready);
endinterface

interface lfrf_cfg_if;
	logic valid;
	logic ready;
	logic [6:0] line_buffer_size;
	modport source (output valid, output line_buffer_size, input ready);
	modport sink (input valid, input line_buffer_size, output ready);
endinterface
`default_nettype wire

[hdl/lfrf_ram.sv]
`default_nettype none
module lfrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/lfrf_seq.sv]
`default_nettype none
module lfrf_seq (
	input wire logic clk,
	input wire logic arst_n,
	lfrf_in_if.sink req,
	input wire logic out_free,
	input wire logic [5:0] lim,
	output logic emit,
	output lfrf_pkg::res_t res,
	output logic ram_we,
	output logic [lfrf_pkg::AW-1:0] ram_waddr,
	output logic [7:0] ram_wdata,
	output logic ram_re,
	output logic [lfrf_pkg::AW-1:0] ram_raddr,
	input wire logic [7:0] ram_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LFCHK,
		S_LNRD,
		S_LNOUT,
		S_LNEND,
		S_NOLINE,
		S_CHOUT
	} state_t;

	state_t state_q;
	logic [lfrf_pkg::AW-1:0] wr_q, rd_q, idx_q, len_q, p_q;
	logic [5:0] k_q, cnt_q;
	logic [7:0] t0_q;
	logic [1:0] tlen_q;

	logic acc, is_term, chunk_last, full;
	logic [lfrf_pkg::AW-1:0] idx_nx, p_nx, wr_nx;
	logic [5:0] elen;

	assign req.ready = (state_q == S_IDLE) && out_free;
	assign acc = req.valid && req.ready;
	assign is_term = (ram_rdata == lfrf_pkg::CHAR_CR) || (ram_rdata == lfrf_pkg::CHAR_LF);
	assign idx_nx = lfrf_pkg::wrap_next(idx_q);
	assign p_nx = lfrf_pkg::wrap_next(p_q);
	assign wr_nx = lfrf_pkg::wrap_next(wr_q);
	assign full = (wr_nx == rd_q);
	assign elen = (lfrf_pkg::CW'(len_q) >= lfrf_pkg::CW'(lim)) ? lim : 6'(len_q);
	assign chunk_last = (cnt_q == 6'd1) || (p_nx == wr_q)
		|| (p_q == lfrf_pkg::AW'(lfrf_pkg::DEPTH - 1));

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = wr_q;
		ram_wdata = req.rx_byte;
		ram_re = 1'b0;
		ram_raddr = idx_q;
		emit = 1'b0;
		res = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.kind)
						lfrf_pkg::KIND_PUSH: begin
							emit = 1'b1;
							res.last = 1'b1;
							if (full) begin
								res.status = lfrf_pkg::ST_DROPPED;
							end else begin
								ram_we = 1'b1;
								res.status = lfrf_pkg::ST_STORED;
							end
						end
						lfrf_pkg::KIND_LINE: begin
							if (wr_q == rd_q) begin
								emit = 1'b1;
								res.status = lfrf_pkg::ST_NO_LINE;
								res.last = 1'b1;
							end else begin
								ram_re = 1'b1;
								ram_raddr = rd_q;
							end
						end
						lfrf_pkg::KIND_CHUNK: begin
							if ((wr_q == rd_q) || (req.max_count == 6'd0)) begin
								emit = 1'b1;
								res.status = lfrf_pkg::ST_EMPTY;
								res.last = 1'b1;
							end else begin
								ram_re = 1'b1;
								ram_raddr = rd_q;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (!is_term || ram_rdata == lfrf_pkg::CHAR_CR) begin
					ram_re = (idx_nx != wr_q);
					ram_raddr = idx_nx;
				end
			end
			S_LNRD: begin
				ram_re = (k_q != elen);
				ram_raddr = p_q;
			end
			S_LNOUT: begin
				emit = out_free;
				res.status = lfrf_pkg::ST_LINE_BYTE;
				res.data_byte = ram_rdata;
			end
			S_LNEND: begin
				emit = out_free;
				res.status = lfrf_pkg::ST_LINE_END;
				res.line_length = elen;
				res.term_first = t0_q;
				res.term_count = tlen_q;
				res.last = 1'b1;
			end
			S_NOLINE: begin
				emit = out_free;
				res.status = lfrf_pkg::ST_NO_LINE;
				res.last = 1'b1;
			end
			S_CHOUT: begin
				emit = out_free;
				res.status = lfrf_pkg::ST_CHUNK_BYTE;
				res.data_byte = ram_rdata;
				res.last = chunk_last;
				ram_re = out_free && !chunk_last;
				ram_raddr = p_nx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wr_q <= '0;
			rd_q <= '0;
			idx_q <= '0;
			len_q <= '0;
			p_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			t0_q <= '0;
			tlen_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (req.kind)
							lfrf_pkg::KIND_PUSH: begin
								if (!full) begin
									wr_q <= wr_nx;
								end
							end
							lfrf_pkg::KIND_LINE: begin
								if (wr_q != rd_q) begin
									idx_q <= rd_q;
									len_q <= '0;
									state_q <= S_SCAN;
								end
							end
							lfrf_pkg::KIND_CHUNK: begin
								if ((wr_q != rd_q) && (req.max_count != 6'd0)) begin
									p_q <= rd_q;
									cnt_q <= req.max_count;
									state_q <= S_CHOUT;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					idx_q <= idx_nx;
					if (is_term) begin
						t0_q <= ram_rdata;
						p_q <= rd_q;
						k_q <= '0;
						if ((ram_rdata == lfrf_pkg::CHAR_CR) && (idx_nx != wr_q)) begin
							state_q <= S_LFCHK;
						end else begin
							tlen_q <= 2'd1;
							state_q <= S_LNRD;
						end
					end else begin
						len_q <= len_q + 1'b1;
						if (idx_nx == wr_q) begin
							state_q <= S_NOLINE;
						end
					end
				end
				S_LFCHK: begin
					if (ram_rdata == lfrf_pkg::CHAR_LF) begin
						tlen_q <= 2'd2;
						idx_q <= idx_nx;
					end else begin
						tlen_q <= 2'd1;
					end
					state_q <= S_LNRD;
				end
				S_LNRD: begin
					state_q <= (k_q == elen) ? S_LNEND : S_LNOUT;
				end
				S_LNOUT: begin
					if (out_free) begin
						p_q <= p_nx;
						k_q <= k_q + 1'b1;
						state_q <= S_LNRD;
					end
				end
				S_LNEND: begin
					if (out_free) begin
						rd_q <= idx_q;
						state_q <= S_IDLE;
					end
				end
				S_NOLINE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_CHOUT: begin
					if (out_free) begin
						if (chunk_last) begin
							rd_q <= p_nx;
							state_q <= S_IDLE;
						end else begin
							p_q <= p_nx;
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/line_framed_rx_fifo_core.sv]
// push: result in the cycle after the request beat, next request taken once it leaves
// take line: the scan reads each byte through the terminator, checks the byte after a cr
// when there is one, then reads and sends each kept line byte in turn, then the end beat
// take chunk: reads the first byte, then one byte beat per cycle while the sink is ready
// reset: both indices zero, line size 64; byte store contents are not cleared
`default_nettype none
`include "line_framed_rx_fifo_core_macros.svh"
module line_framed_rx_fifo_core (
	input wire logic clk,
	input wire logic arst_n,
	lfrf_in_if.sink req,
	lfrf_out_if.source rsp,
	lfrf_cfg_if.sink cfg
);

	logic [6:0] size_q;
	logic [5:0] lim;
	logic rsp_valid_q;
	lfrf_pkg::res_t rsp_q;
	logic out_free, emit;
	lfrf_pkg::res_t res;
	logic ram_we, ram_re;
	logic [lfrf_pkg::AW-1:0] ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;
	logic push_acc, end_beat;

	assign cfg.ready = 1'b1;
	assign lim = (size_q == 7'd0) ? 6'd0
		: (size_q > 7'(lfrf_pkg::LINE_MAX)) ? 6'(lfrf_pkg::LINE_MAX - 1)
		: 6'(size_q - 7'd1);
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 7'(lfrf_pkg::LINE_MAX);
		end else if (cfg.valid) begin
			size_q <= cfg.line_buffer_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_q.status;
	assign rsp.data_byte = rsp_q.data_byte;
	assign rsp.line_length = rsp_q.line_length;
	assign rsp.term_first = rsp_q.term_first;
	assign rsp.term_count = rsp_q.term_count;
	assign rsp.last = rsp_q.last;

	assign push_acc = req.valid && req.ready && (req.kind == lfrf_pkg::KIND_PUSH);
	assign end_beat = rsp.valid && (rsp.status == lfrf_pkg::ST_LINE_END);

	lfrf_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.out_free(out_free),
		.lim(lim),
		.emit(emit),
		.res(res),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	lfrf_ram #(
		.WIDTH(8),
		.DEPTH(lfrf_pkg::DEPTH)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	`LFRF_ASSERT_IMP(a_emit_free, emit, out_free, "beat produced while output register busy")
	`LFRF_ASSERT_NXT(a_push_rsp, push_acc, rsp.valid && rsp.last, "push without response beat")
	`LFRF_ASSERT_IMP(a_write_push, ram_we, push_acc, "store written outside a push")
	`LFRF_ASSERT_IMP(a_end_term, end_beat, rsp.term_count != 2'd0 && rsp.last, "bad line end")

endmodule
`default_nettype wire
